// File: src/mhv_pkg.sv
package mhv_pkg;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_ENTER_THR  = 3'd0,
    REG_EXIT_THR   = 3'd1,
    REG_MON_PERIOD = 3'd2,
    REG_POWER_LEAD = 3'd3,
    REG_WATER_SMP  = 3'd4,
    REG_BLINK      = 3'd5,
    REG_TIMEOUT    = 3'd6
  } reg_index_t;

  localparam int unsigned CFG_DATA_W  = 20;
  localparam int unsigned THR_W       = 12;
  localparam int unsigned COUNTDOWN_W = 20;
  localparam int unsigned LEAD_W      = 10;
  localparam int unsigned PHASE_W     = 16;

  // Reset values
  localparam logic [THR_W-1:0]       ENTER_THR_RST  = 12'd1900;
  localparam logic [THR_W-1:0]       EXIT_THR_RST   = 12'd1840;
  localparam logic [COUNTDOWN_W-1:0] MON_PERIOD_RST = 20'd600000;
  localparam logic [LEAD_W-1:0]      POWER_LEAD_RST = 10'd20;
  localparam logic [PHASE_W-1:0]     WATER_SMP_RST  = 16'd10;
  localparam logic [PHASE_W-1:0]     BLINK_RST      = 16'd500;
  localparam logic [PHASE_W-1:0]     TIMEOUT_RST    = 16'd2000;
  localparam logic [COUNTDOWN_W-1:0] COUNTDOWN_RST  = 20'd100000;

  localparam logic [THR_W-1:0] READING_MAX = 12'hFFF;

  typedef struct packed {
    logic [THR_W-1:0]       enter_thr;
    logic [THR_W-1:0]       exit_thr;
    logic [COUNTDOWN_W-1:0] mon_period;
    logic [LEAD_W-1:0]      power_lead;
    logic [PHASE_W-1:0]     water_smp;
    logic [PHASE_W-1:0]     blink;
    logic [PHASE_W-1:0]     timeout;
  } cfg_t;

  typedef struct packed {
    logic                   watering;
    logic [COUNTDOWN_W-1:0] countdown;
    logic [PHASE_W-1:0]     blink_phase;
    logic [PHASE_W-1:0]     water_phase;
    logic [PHASE_W-1:0]     timeout_cnt;
    logic                   power;
    logic                   led;
  } ctrl_state_t;

  typedef struct packed {
    logic             timed_out;
    logic [THR_W-1:0] reading_mv;
    logic             sample_taken;
    logic             led_on;
    logic             sensor_power;
    logic             valve_open;
  } result_t;

  // Phase counter advance; a limit of zero behaves as one
  function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] phase,
                                                    input logic [PHASE_W-1:0] limit);
    logic [PHASE_W:0] n;
    logic [PHASE_W:0] lim;
    n   = {1'b0, phase} + (PHASE_W+1)'(1);
    lim = (limit == '0) ? (PHASE_W+1)'(1) : {1'b0, limit};
    return (n >= lim) ? '0 : n[PHASE_W-1:0];
  endfunction

endpackage

// File: src/moisture_hysteresis_valve_controller_core.sv
// Channel  Dir  Signals                 Payload
// s_axis   in   s_tvalid/tready/tdata   sensor_code, one transaction per 1 ms tick
// m_axis   out  m_tvalid/tready/tdata   one result transaction per tick
// cfg      in   cfg_we/index/wdata      register writes, no read-back
//
// Each transaction passes an input register and then the step logic, which
// updates the controller state and loads the result register; one transaction
// per cycle is sustained while the skid entry is free. The output register has
// one skid entry behind it; input stalls only while that entry is occupied.
// Synchronous reset (rst) restores config and state registers to defaults and
// clears valid flags; the first monitoring sample is then 100000 ticks away.
module moisture_hysteresis_valve_controller_core
  import mhv_pkg::*;
#(
  parameter int unsigned SENSOR_BITS = 10
)
(
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [((SENSOR_BITS+7)/8)*8-1:0] s_tdata,  // [SENSOR_BITS-1:0] sensor_code
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [0] valve_open, [1] sensor_power, [2] led_on, [3] sample_taken,
  // [15:4] reading_mv, [16] timed_out
  output logic [23:0]                     m_tdata,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_wdata
);

  cfg_t                   cfg;
  ctrl_state_t            st;
  ctrl_state_t            st_next;
  result_t                res;
  result_t                out_res;
  logic                   in_valid;
  logic [SENSOR_BITS-1:0] in_code;
  logic                   adv;
  logic                   buf_ready;

  mhv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register
  assign adv      = in_valid && buf_ready;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) in_code <= s_tdata[SENSOR_BITS-1:0];
  end

  mhv_step #(
    .SENSOR_BITS (SENSOR_BITS)
  ) u_step (
    .cfg     (cfg),
    .st      (st),
    .code    (in_code),
    .st_next (st_next),
    .res     (res)
  );

  // Controller state, advanced once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      st.watering    <= 1'b0;
      st.countdown   <= COUNTDOWN_RST;
      st.blink_phase <= '0;
      st.water_phase <= '0;
      st.timeout_cnt <= '0;
      st.power       <= 1'b0;
      st.led         <= 1'b0;
    end else if (adv) begin
      st <= st_next;
    end
  end

  mhv_out_skid u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (adv),
    .push_data  (res),
    .push_ready (buf_ready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_res)
  );

  assign m_tdata = {7'd0, out_res.timed_out, out_res.reading_mv, out_res.sample_taken,
                    out_res.led_on, out_res.sensor_power, out_res.valve_open};

  // A timeout pulse only comes from a watering sample that kept the valve open
  a_timeout_in_watering: assert property (@(posedge clk) disable iff (rst)
    adv && res.timed_out |-> res.valve_open && res.sample_taken)
    else $error("timeout pulse without watering sample");

  // Entry into watering always comes from a sample
  a_entry_sampled: assert property (@(posedge clk) disable iff (rst)
    adv && !st.watering && res.valve_open |-> res.sample_taken)
    else $error("watering entered without a sample");

  // Leaving watering arms a monitoring sample for the next tick
  a_exit_arms_sample: assert property (@(posedge clk) disable iff (rst)
    adv && st.watering && !res.valve_open |=> st.countdown == '0 && !st.led)
    else $error("exit from watering did not arm a sample");

  // The skid entry is only occupied behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    !buf_ready |-> m_tvalid)
    else $error("skid entry occupied with empty output register");

endmodule

// File: src/mhv_cfg_regs.sv
module mhv_cfg_regs
  import mhv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  // Register file, written by index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enter_thr  <= ENTER_THR_RST;
      cfg.exit_thr   <= EXIT_THR_RST;
      cfg.mon_period <= MON_PERIOD_RST;
      cfg.power_lead <= POWER_LEAD_RST;
      cfg.water_smp  <= WATER_SMP_RST;
      cfg.blink      <= BLINK_RST;
      cfg.timeout    <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_ENTER_THR:  cfg.enter_thr  <= cfg_wdata[THR_W-1:0];
        REG_EXIT_THR:   cfg.exit_thr   <= cfg_wdata[THR_W-1:0];
        REG_MON_PERIOD: cfg.mon_period <= cfg_wdata[COUNTDOWN_W-1:0];
        REG_POWER_LEAD: cfg.power_lead <= cfg_wdata[LEAD_W-1:0];
        REG_WATER_SMP:  cfg.water_smp  <= cfg_wdata[PHASE_W-1:0];
        REG_BLINK:      cfg.blink      <= cfg_wdata[PHASE_W-1:0];
        REG_TIMEOUT:    cfg.timeout    <= cfg_wdata[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/mhv_step.sv
module mhv_step
  import mhv_pkg::*;
#(
  parameter int unsigned SENSOR_BITS = 10
)
(
  input  cfg_t                   cfg,
  input  ctrl_state_t            st,
  input  logic [SENSOR_BITS-1:0] code,
  output ctrl_state_t            st_next,
  output result_t                res
);

  localparam int unsigned RD_W  = SENSOR_BITS + 2;
  localparam int unsigned CMP_W = (RD_W > THR_W) ? RD_W : THR_W;

  logic [CMP_W-1:0] reading;
  logic             above_enter;
  logic             below_exit;
  logic             sampled;
  logic             pulse;
  logic [PHASE_W-1:0] tc_inc;

  assign reading     = CMP_W'({code, 2'b00});
  assign above_enter = reading > CMP_W'(cfg.enter_thr);
  assign below_exit  = reading < CMP_W'(cfg.exit_thr);

  // One tick: monitoring work first, then watering on the same reading
  always_comb begin
    st_next = st;
    sampled = 1'b0;
    pulse   = 1'b0;

    if (!st.watering) begin
      if (st.countdown == '0) begin
        sampled = 1'b1;
        if (above_enter) begin
          st_next.timeout_cnt = '0;
          st_next.watering    = 1'b1;
        end else begin
          st_next.power = 1'b0;
        end
        st_next.countdown = (cfg.mon_period != '0) ?
                            cfg.mon_period - COUNTDOWN_W'(1) : '0;
      end else begin
        st_next.countdown = st.countdown - COUNTDOWN_W'(1);
      end
      if (st.countdown == COUNTDOWN_W'(cfg.power_lead)) st_next.power = 1'b1;
    end

    // count starts from the cleared value when watering was just entered
    tc_inc = st_next.timeout_cnt + PHASE_W'(1);

    if (st_next.watering) begin
      if (st.blink_phase == '0) st_next.led = !st_next.led;
      if (st.water_phase == '0) begin
        sampled = 1'b1;
        if (below_exit) begin
          st_next.led       = 1'b0;
          st_next.watering  = 1'b0;
          st_next.countdown = '0;
        end else if (tc_inc == cfg.timeout) begin
          pulse               = 1'b1;
          st_next.timeout_cnt = '0;
        end else begin
          st_next.timeout_cnt = tc_inc;
        end
      end
      st_next.blink_phase = next_phase(st.blink_phase, cfg.blink);
      st_next.water_phase = next_phase(st.water_phase, cfg.water_smp);
    end
  end

  // Result fields, reading saturates at the 12-bit range
  always_comb begin
    res.valve_open   = st_next.watering;
    res.sensor_power = st_next.power;
    res.led_on       = st_next.led;
    res.sample_taken = sampled;
    res.reading_mv   = (reading > CMP_W'(READING_MAX)) ? READING_MAX : reading[THR_W-1:0];
    res.timed_out    = pulse;
  end

endmodule

// File: src/mhv_out_skid.sv
module mhv_out_skid
  import mhv_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    push_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    take;

  assign take       = out_valid && out_ready;
  assign push_ready = !skid_valid;

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: dv/tb_moisture_hysteresis_valve_controller_core.sv
module tb_moisture_hysteresis_valve_controller_core;
  import mhv_pkg::*;

  localparam int CODE_W   = 10;
  localparam int CODE_MAX = 1023;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata   = '0;  // [9:0] sensor_code
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  // [0] valve_open, [1] sensor_power, [2] led_on, [3] sample_taken,
  // [15:4] reading_mv, [16] timed_out
  logic [23:0]            m_tdata;
  logic                   cfg_we    = 1'b0;
  reg_index_t             cfg_index = REG_ENTER_THR;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Register shadow
  logic [THR_W-1:0]       enter_thr_r  = ENTER_THR_RST;
  logic [THR_W-1:0]       exit_thr_r   = EXIT_THR_RST;
  logic [COUNTDOWN_W-1:0] mon_period_r = MON_PERIOD_RST;
  logic [LEAD_W-1:0]      lead_r       = POWER_LEAD_RST;
  logic [PHASE_W-1:0]     water_smp_r  = WATER_SMP_RST;
  logic [PHASE_W-1:0]     blink_r      = BLINK_RST;
  logic [PHASE_W-1:0]     timeout_r    = TIMEOUT_RST;

  // Controller state as the testbench tracks it
  logic                   watering_q  = 1'b0;
  logic [COUNTDOWN_W-1:0] countdown_q = COUNTDOWN_RST;
  logic [PHASE_W-1:0]     blink_ph_q  = '0;
  logic [PHASE_W-1:0]     water_ph_q  = '0;
  logic [PHASE_W-1:0]     tmo_cnt_q   = '0;
  logic                   power_q     = 1'b0;
  logic                   led_q       = 1'b0;

  result_t     tick_results_due[$];
  int          mismatches = 0;
  bit          no_idle    = 1'b0;
  int unsigned ready_hold = 0;

  moisture_hysteresis_valve_controller_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Phase counter step; zero limit counts as one
  function automatic logic [PHASE_W-1:0] step_phase(input logic [PHASE_W-1:0] phase,
                                                    input logic [PHASE_W-1:0] limit);
    logic [PHASE_W:0] nxt;
    logic [PHASE_W:0] top;
    nxt = {1'b0, phase} + 1'b1;
    top = (limit == '0) ? (PHASE_W+1)'(1) : {1'b0, limit};
    return (nxt >= top) ? '0 : nxt[PHASE_W-1:0];
  endfunction

  // One tick of the controller: updates tracked state, returns the tick result
  task automatic advance_controller(input logic [CODE_W-1:0] code, output result_t res);
    logic [THR_W-1:0]       reading;
    logic [COUNTDOWN_W-1:0] cd;
    logic                   sampled;
    logic                   pulse;
    reading = {code, 2'b00};
    sampled = 1'b0;
    pulse   = 1'b0;
    // monitoring schedule and power lead
    if (!watering_q) begin
      cd = countdown_q;
      if (cd == '0) begin
        sampled = 1'b1;
        if (reading > enter_thr_r) begin
          tmo_cnt_q  = '0;
          watering_q = 1'b1;
        end else begin
          power_q = 1'b0;
        end
        countdown_q = (mon_period_r != '0) ? mon_period_r - 1'b1 : '0;
      end else begin
        countdown_q = cd - 1'b1;
      end
      if (cd == {10'd0, lead_r}) power_q = 1'b1;
    end
    // watering: blink, short-interval sample, timeout count
    if (watering_q) begin
      if (blink_ph_q == '0) led_q = !led_q;
      if (water_ph_q == '0) begin
        sampled = 1'b1;
        if (reading < exit_thr_r) begin
          led_q       = 1'b0;
          watering_q  = 1'b0;
          countdown_q = '0;
        end else begin
          tmo_cnt_q = tmo_cnt_q + 1'b1;
          if (tmo_cnt_q == timeout_r) begin
            pulse     = 1'b1;
            tmo_cnt_q = '0;
          end
        end
      end
      blink_ph_q = step_phase(blink_ph_q, blink_r);
      water_ph_q = step_phase(water_ph_q, water_smp_r);
    end
    res.valve_open   = watering_q;
    res.sensor_power = power_q;
    res.led_on       = led_q;
    res.sample_taken = sampled;
    res.reading_mv   = reading;
    res.timed_out    = pulse;
  endtask

  // Sensor code biased toward the threshold that matters in the current mode
  function automatic logic [CODE_W-1:0] pick_code(input int floor_code);
    int thr;
    int r;
    int c;
    thr = watering_q ? int'(exit_thr_r >> 2) : int'(enter_thr_r >> 2);
    r   = $urandom_range(0, 99);
    if (r < 8)
      c = (r < 4) ? 0 : CODE_MAX;
    else if (r < 45)
      c = thr + int'($urandom_range(0, 4)) - 2;
    else if (r < 80)
      c = watering_q ? int'($urandom_range(thr, CODE_MAX)) : int'($urandom_range(0, thr));
    else
      c = $urandom_range(0, CODE_MAX);
    if (c < floor_code) c = floor_code;
    if (c > CODE_MAX) c = CODE_MAX;
    return c[CODE_W-1:0];
  endfunction

  // Send one tick transaction; called and returns at a falling edge
  task automatic send_tick(input logic [CODE_W-1:0] code);
    int      gap;
    result_t res;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {6'd0, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    advance_controller(code, res);
    tick_results_due.push_back(res);
  endtask

  // Filler ticks until the next tick evaluates the reading, then that tick
  task automatic sample_with(input logic [CODE_W-1:0] code);
    while (!((!watering_q && countdown_q == '0) || (watering_q && water_ph_q == '0)))
      send_tick(CODE_W'($urandom_range(0, CODE_MAX)));
    send_tick(code);
  endtask

  task automatic run_random(input int n, input int floor_code);
    repeat (n) send_tick(pick_code(floor_code));
  endtask

  // Stop sending and let every result drain out
  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (tick_results_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_ENTER_THR:  enter_thr_r  = value[THR_W-1:0];
      REG_EXIT_THR:   exit_thr_r   = value[THR_W-1:0];
      REG_MON_PERIOD: mon_period_r = value[COUNTDOWN_W-1:0];
      REG_POWER_LEAD: lead_r       = value[LEAD_W-1:0];
      REG_WATER_SMP:  water_smp_r  = value[PHASE_W-1:0];
      REG_BLINK:      blink_r      = value[PHASE_W-1:0];
      REG_TIMEOUT:    timeout_r    = value[PHASE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] enter_v, exit_v, period_v,
                                lead_v, water_v, blink_v, timeout_v);
    wait_idle();
    write_reg(REG_ENTER_THR, enter_v);
    write_reg(REG_EXIT_THR, exit_v);
    write_reg(REG_MON_PERIOD, period_v);
    write_reg(REG_POWER_LEAD, lead_v);
    write_reg(REG_WATER_SMP, water_v);
    write_reg(REG_BLINK, blink_v);
    write_reg(REG_TIMEOUT, timeout_v);
  endtask

  // Countdown from reset to the first monitoring sample, default lead and thresholds
  task automatic test_first_sample();
    write_reg(REG_MON_PERIOD, 20'd30);
    no_idle = 1'b1;
    repeat (int'(COUNTDOWN_RST)) send_tick(CODE_W'($urandom_range(0, CODE_MAX)));
    no_idle = 1'b0;
    send_tick(CODE_W'(CODE_MAX));
  endtask

  // Readings exactly at and one step past both thresholds
  task automatic test_hysteresis_edges();
    sample_with(exit_thr_r[THR_W-1:2]);
    sample_with(CODE_W'(CODE_MAX));
    sample_with(exit_thr_r[THR_W-1:2] - 1'b1);
    // forced sample right after exit, equal to the enter threshold
    sample_with(enter_thr_r[THR_W-1:2]);
    sample_with(enter_thr_r[THR_W-1:2] + 1'b1);
    sample_with(CODE_W'(CODE_MAX));
    sample_with('0);
    sample_with('0);
  endtask

  task automatic test_register_extremes();
    // maximums but a period of one: never enters, sample every tick, lead beyond period
    apply_settings(20'hFFFFF, 20'hFFFFF, 20'd1, 20'h3FF, 20'hFFFF, 20'hFFFF, 20'hFFFF);
    run_random(60, 0);
    // all zeros: zero period, zero lead, intervals act as one, no timeout limit
    apply_settings('0, '0, '0, '0, '0, '0, '0);
    repeat (3) sample_with('0);
    run_random(60, 0);
    // longest period; any monitoring sample re-enters, so the reload never runs out
    apply_settings('0, 20'(THR_W'($urandom_range(1000, 3000))), 20'hFFFFF, 20'h3FF,
                   20'd3, 20'd2, 20'd4);
    run_random(80, 1);
  endtask

  task automatic test_random_settings();
    int enter_v;
    int exit_v;
    for (int k = 0; k < 10; k++) begin
      enter_v = $urandom_range(0, 4095);
      if ($urandom_range(0, 3) == 0)
        exit_v = $urandom_range(0, 4095);
      else
        exit_v = (enter_v > 200) ? enter_v - int'($urandom_range(0, 200)) : enter_v;
      // unused upper bits of the write data carry noise
      apply_settings({8'($urandom), 12'(enter_v)}, {8'($urandom), 12'(exit_v)},
                     20'($urandom_range(0, 40)), {10'($urandom), 10'($urandom_range(0, 48))},
                     20'($urandom_range(0, 6)), 20'($urandom_range(0, 9)),
                     20'($urandom_range(0, 6)));
      no_idle = (k == 4);
      run_random(80, 0);
      no_idle = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[16:0]);
      if (tick_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = tick_results_due.pop_front();
        check_field("valve_open", want.valve_open, got.valve_open);
        check_field("sensor_power", want.sensor_power, got.sensor_power);
        check_field("led_on", want.led_on, got.led_on);
        check_field("sample_taken", want.sample_taken, got.sample_taken);
        check_field("reading_mv", want.reading_mv, got.reading_mv);
        check_field("timed_out", want.timed_out, got.timed_out);
        check_field("tdata padding", 0, m_tdata[23:17]);
      end
      ready_hold = no_idle ? 0 : $urandom_range(0, 8);
    end
  end

  // Receiver backpressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready = 1'b0;
    end else if (ready_hold != 0) begin
      m_tready   = 1'b0;
      ready_hold = ready_hold - 1;
    end else begin
      m_tready = 1'b1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_first_sample();
    test_hysteresis_edges();
    test_register_extremes();
    test_random_settings();
    wait_idle();
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: moisture_hysteresis_valve_controller_core.f
src/mhv_pkg.sv
src/mhv_cfg_regs.sv
src/mhv_step.sv
src/mhv_out_skid.sv
src/moisture_hysteresis_valve_controller_core.sv
dv/tb_moisture_hysteresis_valve_controller_core.sv
